/* rtl/positional_list_engine_assert.svh */
// Assertion macros for the positional list engine.
// Included by the top level; no other dependencies.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// Check cons in the same cycle whenever ante holds.
`define PLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Check cons in the cycle after ante holds.
`define PLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define PLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/ple_pkg.sv */
// Shared types and constants of the positional list engine.
// Used by the cell and the top level; no dependencies.
package ple_pkg;

    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int FIDX_W   = 7;
    localparam int COUNT_W  = 7;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE_AT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE_VAL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REPLACE    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // Operation broadcast to every cell in the commit cycle
    typedef enum logic [1:0] {
        CO_HOLD,
        CO_INSERT,
        CO_REMOVE,
        CO_REPLACE
    } t_cell_op;

    typedef struct packed {
        logic                       capture;   // latch match and position flags
        t_cell_op                   op;
        logic                       by_value;  // remove uses first-match mask
        logic signed [VALUE_W-1:0]  value;
    } t_cell_bus;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MATCH = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

endpackage

/* rtl/positional_list_engine.sv */
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit values held in
// a chain of cells, one element per cell, that shift toward each other on insert and
// remove. Each command runs in two steps: one in which every cell compares its element
// against the command value and latches its position flags while the signed position is
// resolved against the count, and one in which the first match is selected and the whole
// chain shifts or writes at once. A new command is taken in the commit cycle, so a new
// command enters its match step as the last one commits, while the result register is
// free; a stalled result holds the commit. Cell contents need no clearing after reset: only
// cells below the count are ever read. Errors leave the list unchanged.
// Depends on ple_pkg, ple_cell, ple_first_match and positional_list_engine_assert.svh.
`include "positional_list_engine_assert.svh"

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [CMD_W-1:0]           i_cmd,
    input  logic signed [POS_W-1:0]    i_position,
    input  logic signed [VALUE_W-1:0]  i_value,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [VALUE_W-1:0]  o_data,
    output logic signed [FIDX_W-1:0]   o_found_index,
    output logic [COUNT_W-1:0]         o_count
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int PW = ((LW > POS_W) ? LW : POS_W) + 2;

    t_state                    r_state;
    t_state                    n_state;
    logic [CMD_W-1:0]          r_cmd;
    logic signed [POS_W-1:0]   r_position;
    logic signed [VALUE_W-1:0] r_value;
    logic                      r_ok_ins;
    logic                      r_ok_pos;
    logic [LW-1:0]             r_length;
    logic [LW-1:0]             n_length;
    logic                      r_out_valid;
    logic [STATUS_W-1:0]       r_status;
    logic [STATUS_W-1:0]       n_status;
    logic signed [VALUE_W-1:0] r_data;
    logic signed [VALUE_W-1:0] n_data;
    logic signed [FIDX_W-1:0]  r_fidx;
    logic signed [FIDX_W-1:0]  n_fidx;
    logic [COUNT_W-1:0]        r_count;

    logic                      in_accept;
    logic                      out_free;
    logic                      commit;
    logic signed [PW-1:0]      pos_ext;
    logic signed [PW-1:0]      len_ext;
    logic signed [PW-1:0]      pos_adj;
    logic                      ok_ins;
    logic                      ok_pos;
    logic [IW-1:0]             idx_cmb;
    t_cell_op                  exec_op;
    t_cell_bus                 cell_bus;
    logic signed [VALUE_W-1:0] elem     [CAPACITY];
    logic signed [VALUE_W-1:0] left_in  [CAPACITY];
    logic signed [VALUE_W-1:0] right_in [CAPACITY];
    logic [CAPACITY-1:0]       match;
    logic [CAPACITY-1:0]       sel;
    logic [CAPACITY-1:0]       vge;
    logic                      found;
    logic [IW-1:0]             first_idx;
    logic signed [VALUE_W-1:0] rd_data;

    // Handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign commit     = (r_state == S_EXEC) && out_free;
    assign o_in_stall = !((r_state == S_IDLE) || commit);
    assign in_accept  = i_in_valid && !o_in_stall;

    // Resolve the signed position against the current count
    assign pos_ext = PW'(r_position);
    assign len_ext = signed'({{(PW - LW){1'b0}}, r_length});
    assign pos_adj = pos_ext + (r_position[POS_W-1] ? len_ext : PW'(0));
    assign ok_ins  = !pos_adj[PW-1] && (pos_adj <= len_ext);
    assign ok_pos  = !pos_adj[PW-1] && (pos_adj < len_ext);
    assign idx_cmb = pos_adj[IW-1:0];

    // Cell chain
    assign cell_bus.capture  = (r_state == S_MATCH);
    assign cell_bus.op       = commit ? exec_op : CO_HOLD;
    assign cell_bus.by_value = (r_cmd == CMD_REMOVE_VAL);
    assign cell_bus.value    = r_value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign left_in[g] = '0;
        end else begin : g_mid_l
            assign left_in[g] = elem[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign right_in[g] = '0;
        end else begin : g_mid_r
            assign right_in[g] = elem[g+1];
        end

        ple_cell #(
            .ID (g),
            .IW (IW),
            .LW (LW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_bus    (cell_bus),
            .i_idx    (idx_cmb),
            .i_length (r_length),
            .i_vge    (vge[g]),
            .i_left   (left_in[g]),
            .i_right  (right_in[g]),
            .o_elem   (elem[g]),
            .o_match  (match[g]),
            .o_sel    (sel[g])
        );
    end

    ple_first_match #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_first (
        .i_match (match),
        .o_found (found),
        .o_index (first_idx),
        .o_ge    (vge)
    );

    // Read the selected cell
    always_comb begin
        rd_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_data = rd_data | (elem[i] & {VALUE_W{sel[i]}});
        end
    end

    // Decide result and chain operation in the commit cycle
    always_comb begin
        n_status = ST_OK;
        n_data   = '0;
        n_fidx   = '1;
        n_length = r_length;
        exec_op  = CO_HOLD;
        unique case (r_cmd)
            CMD_INSERT: begin
                if (!r_ok_ins) begin
                    n_status = ST_RANGE;
                end else if (r_length == LW'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    exec_op  = CO_INSERT;
                    n_length = r_length + LW'(1);
                end
            end
            CMD_REMOVE_AT: begin
                if (!r_ok_pos) begin
                    n_status = ST_RANGE;
                end else begin
                    n_data   = rd_data;
                    exec_op  = CO_REMOVE;
                    n_length = r_length - LW'(1);
                end
            end
            CMD_REMOVE_VAL: begin
                if (!found) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_data   = r_value;
                    n_fidx   = FIDX_W'(first_idx);
                    exec_op  = CO_REMOVE;
                    n_length = r_length - LW'(1);
                end
            end
            CMD_REPLACE: begin
                if (!r_ok_pos) begin
                    n_status = ST_RANGE;
                end else begin
                    exec_op = CO_REPLACE;
                end
            end
            CMD_FIND: begin
                if (!found) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_fidx = FIDX_W'(first_idx);
                end
            end
            CMD_READ: begin
                if (!r_ok_pos) begin
                    n_status = ST_RANGE;
                end else begin
                    n_data = rd_data;
                end
            end
            default: ;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_accept) n_state = S_MATCH;
            S_MATCH: n_state = S_EXEC;
            S_EXEC: begin
                if (commit) begin
                    n_state = in_accept ? S_MATCH : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_length    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= commit || (r_out_valid && i_out_stall);
            if (commit) begin
                r_length <= n_length;
            end
        end
    end

    // Hold the command, the resolved flags and the result
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd      <= i_cmd;
            r_position <= i_position;
            r_value    <= i_value;
        end
        if (r_state == S_MATCH) begin
            r_ok_ins <= ok_ins;
            r_ok_pos <= ok_pos;
        end
        if (commit) begin
            r_status <= n_status;
            r_data   <= n_data;
            r_fidx   <= n_fidx;
            r_count  <= COUNT_W'(n_length);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_data        = r_data;
    assign o_found_index = r_fidx;
    assign o_count       = r_count;

    `PLE_ASSERT_NEXT(a_accept_to_match, i_clk, i_rst_n, in_accept, r_state == S_MATCH, "accepted command did not enter match cycle")
    `PLE_ASSERT_NEXT(a_length_hold, i_clk, i_rst_n, !commit, $stable(r_length), "count changed outside commit")
    `PLE_ASSERT_NOW(a_length_cap, i_clk, i_rst_n, 1'b1, r_length <= LW'(CAPACITY), "count exceeds capacity")
    `PLE_ASSERT_NEXT(a_commit_result, i_clk, i_rst_n, commit, r_out_valid && (r_count == COUNT_W'(r_length)), "result count disagrees with list count")

endmodule

/* rtl/ple_cell.sv */
// One storage cell of the list chain: holds one element and its flags.
// Depends on ple_pkg; exchanges elements with its two neighbors.
module ple_cell
    import ple_pkg::*;
#(
    parameter int ID = 0,
    parameter int IW = 6,
    parameter int LW = 7
) (
    input  logic                      i_clk,
    input  t_cell_bus                 i_bus,
    input  logic [IW-1:0]             i_idx,
    input  logic [LW-1:0]             i_length,
    input  logic                      i_vge,
    input  logic signed [VALUE_W-1:0] i_left,
    input  logic signed [VALUE_W-1:0] i_right,
    output logic signed [VALUE_W-1:0] o_elem,
    output logic                      o_match,
    output logic                      o_sel
);

    logic signed [VALUE_W-1:0] r_elem;
    logic signed [VALUE_W-1:0] n_elem;
    logic                      r_match;
    logic                      r_ge;
    logic                      r_sel;

    // Pick the next element from the broadcast operation and local flags
    always_comb begin
        n_elem = r_elem;
        unique case (i_bus.op)
            CO_HOLD: ;
            CO_INSERT: begin
                if (r_sel) begin
                    n_elem = i_bus.value;
                end else if (r_ge) begin
                    n_elem = i_left;
                end
            end
            CO_REMOVE: begin
                if (i_bus.by_value ? i_vge : r_ge) begin
                    n_elem = i_right;
                end
            end
            CO_REPLACE: begin
                if (r_sel) begin
                    n_elem = i_bus.value;
                end
            end
        endcase
    end

    // Advance the element; latch match and position flags on capture
    always_ff @(posedge i_clk) begin
        r_elem <= n_elem;
        if (i_bus.capture) begin
            r_match <= (r_elem == i_bus.value) && (LW'(ID) < i_length);
            r_ge    <= (IW'(ID) >= i_idx);
            r_sel   <= (IW'(ID) == i_idx);
        end
    end

    assign o_elem  = r_elem;
    assign o_match = r_match;
    assign o_sel   = r_sel;

endmodule

/* rtl/ple_first_match.sv */
// First-match unit: finds the lowest set match bit of the cell chain.
// Gives its index and the at-or-above mask; no package dependencies.
module ple_first_match #(
    parameter int CAPACITY = 64,
    parameter int IW       = 6
) (
    input  logic [CAPACITY-1:0] i_match,
    output logic                o_found,
    output logic [IW-1:0]       o_index,
    output logic [CAPACITY-1:0] o_ge
);

    logic [CAPACITY-1:0] low_mask;
    logic [CAPACITY-1:0] first_oh;

    // Isolate the lowest set bit with one subtract
    assign low_mask = i_match ^ (i_match - CAPACITY'(1));
    assign first_oh = low_mask & i_match;
    assign o_ge     = ~low_mask | first_oh;
    assign o_found  = |i_match;

    // Encode the one-hot position
    always_comb begin
        o_index = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first_oh[i]) begin
                o_index = o_index | IW'(i);
            end
        end
    end

endmodule

/* tb/sv/positional_list_engine_tb.sv */
// Self-checking testbench for positional_list_engine: a short directed table, then random
// command streams that fill and drain the list, checked against a list model kept here.
// Depends on ple_pkg and the positional_list_engine RTL.
module positional_list_engine_tb;
    import ple_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 1500;
    localparam int QUIET_TAIL   = 200;
    localparam int CYCLE_LIMIT  = 200000;

    // Command codes the block leaves unused
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam logic [VALUE_W-1:0] VMAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VMIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VNEG = 32'hFFFF_FFFF;
    localparam int NO_INDEX = -1;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] data;
        logic signed [FIDX_W-1:0]  fidx;
        logic [COUNT_W-1:0]        count;
    } t_list_result;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [POS_W-1:0]   pos;
        logic signed [VALUE_W-1:0] val;
        logic                      typed;
        t_list_result              want;
    } t_list_cmd;

    typedef struct {
        t_list_cmd item;
        bit        to_end;
        bit        rand_val;
        int        reps;
    } t_table_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [CMD_W-1:0]          i_cmd = '0;
    logic signed [POS_W-1:0]   i_position = '0;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [STATUS_W-1:0]       o_status;
    logic signed [VALUE_W-1:0] o_data;
    logic signed [FIDX_W-1:0]  o_found_index;
    logic [COUNT_W-1:0]        o_count;

    // List model
    logic signed [VALUE_W-1:0] cells [CAPACITY];
    int                        cell_count = 0;
    bit                        growing = 1'b1;

    t_list_result expected_q [$];
    t_table_row   directed_q [$];
    t_list_cmd    cur_item;
    int           row_idx = 0;
    int           rep_done = 0;
    int           random_made = 0;
    int           send_gap = 0;
    int           stall_left = 0;
    int           error_count = 0;
    int           cycles = 0;
    logic         stim_done = 1'b0;

    positional_list_engine #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_data       (o_data),
        .o_found_index(o_found_index),
        .o_count      (o_count)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Execute one command on the list model and return its result
    function automatic t_list_result apply_command(
        logic [CMD_W-1:0]          c,
        logic signed [POS_W-1:0]   pos,
        logic signed [VALUE_W-1:0] v
    );
        t_list_result r;
        int p;
        int hit;
        int drop;
        bit in_range;
        r.status = ST_OK;
        r.data   = '0;
        r.fidx   = FIDX_W'(NO_INDEX);
        p = int'(pos);
        if (p < 0) p += cell_count;
        in_range = (p >= 0) && (p < cell_count);
        hit = -1;
        drop = -1;
        for (int i = cell_count - 1; i >= 0; i--)
            if (cells[i] == v) hit = i;
        case (c)
            CMD_INSERT: begin
                if (p < 0 || p > cell_count) r.status = ST_RANGE;
                else if (cell_count >= CAPACITY) r.status = ST_FULL;
                else begin
                    for (int i = cell_count; i > p; i--) cells[i] = cells[i - 1];
                    cells[p] = v;
                    cell_count++;
                end
            end
            CMD_REMOVE_AT: begin
                if (!in_range) r.status = ST_RANGE;
                else drop = p;
            end
            CMD_REMOVE_VAL: begin
                if (hit < 0) r.status = ST_NOT_FOUND;
                else begin
                    r.fidx = FIDX_W'(hit);
                    drop = hit;
                end
            end
            CMD_REPLACE: begin
                if (!in_range) r.status = ST_RANGE;
                else cells[p] = v;
            end
            CMD_FIND: begin
                if (hit < 0) r.status = ST_NOT_FOUND;
                else r.fidx = FIDX_W'(hit);
            end
            CMD_READ: begin
                if (!in_range) r.status = ST_RANGE;
                else r.data = cells[p];
            end
            default: ;
        endcase
        // Close the gap left by a removed element
        if (drop >= 0) begin
            r.data = cells[drop];
            for (int i = drop; i < cell_count - 1; i++) cells[i] = cells[i + 1];
            cell_count--;
        end
        r.count = COUNT_W'(cell_count);
        return r;
    endfunction

    // Pick a command that mostly hits valid positions and values held in the list
    function automatic t_list_cmd random_command();
        t_list_cmd it;
        int roll;
        int hi;
        int idx;
        it = '0;
        if (cell_count == CAPACITY && $urandom_range(0, 7) == 0) growing = 1'b0;
        if (cell_count == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < (growing ? 45 : 12)) it.cmd = CMD_INSERT;
        else if (roll < (growing ? 55 : 45)) it.cmd = CMD_REMOVE_AT;
        else if (roll < (growing ? 65 : 60)) it.cmd = CMD_REMOVE_VAL;
        else if (roll < 74) it.cmd = CMD_REPLACE;
        else if (roll < 86) it.cmd = CMD_FIND;
        else if (roll < 97) it.cmd = CMD_READ;
        else it.cmd = (roll % 2 == 0) ? CMD_SPARE_6 : CMD_SPARE_7;

        hi = (it.cmd == CMD_INSERT) ? cell_count : cell_count - 1;
        if (hi < 0 || $urandom_range(0, 6) == 0) begin
            it.pos = POS_W'($urandom_range(0, 255));
        end else begin
            idx = $urandom_range(0, hi);
            it.pos = POS_W'($urandom_range(0, 1) ? idx - cell_count : idx);
        end

        roll = $urandom_range(0, 9);
        if (cell_count > 0 &&
            roll < ((it.cmd == CMD_FIND || it.cmd == CMD_REMOVE_VAL) ? 7 : 3)) begin
            it.val = cells[$urandom_range(0, cell_count - 1)];
        end else if (roll < 5) begin
            case ($urandom_range(0, 4))
                0:       it.val = '0;
                1:       it.val = VNEG;
                2:       it.val = VMIN;
                3:       it.val = VMAX;
                default: it.val = 1;
            endcase
        end else begin
            it.val = $urandom();
        end
        return it;
    endfunction

    function automatic bit idling_on();
        return (random_made < RANDOM_ITEMS - QUIET_TAIL) && ((random_made / 150) % 4 != 3);
    endfunction

    task automatic add_row(input logic [CMD_W-1:0] c, input int p,
                           input logic [VALUE_W-1:0] v, input bit typed,
                           input logic [STATUS_W-1:0] st = ST_OK,
                           input logic [VALUE_W-1:0] d = '0, input int fi = NO_INDEX,
                           input int n = 0);
        t_table_row r;
        r.item       = '0;
        r.item.cmd   = c;
        r.item.pos   = POS_W'(p);
        r.item.val   = v;
        r.item.typed = typed;
        r.item.want  = {st, d, fi[FIDX_W-1:0], n[COUNT_W-1:0]};
        r.to_end     = 1'b0;
        r.rand_val   = 1'b0;
        r.reps       = 1;
        directed_q.push_back(r);
    endtask

    // Sender: record each transfer, then present the next command or an idle burst
    always @(posedge i_clk) begin
        t_list_result predicted;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predicted = apply_command(i_cmd, i_position, i_value);
                expected_q.push_back(cur_item.typed ? cur_item.want : predicted);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (idling_on() && $urandom_range(0, 4) == 0) begin
                    send_gap = $urandom_range(0, 3);
                    i_in_valid <= 1'b0;
                end else if (row_idx < directed_q.size() || random_made < RANDOM_ITEMS) begin
                    if (row_idx < directed_q.size()) begin
                        cur_item = directed_q[row_idx].item;
                        if (directed_q[row_idx].to_end) cur_item.pos = POS_W'(cell_count);
                        if (directed_q[row_idx].rand_val) cur_item.val = $urandom();
                        rep_done++;
                        if (rep_done >= directed_q[row_idx].reps) begin
                            row_idx++;
                            rep_done = 0;
                        end
                    end else begin
                        cur_item = random_command();
                        random_made++;
                    end
                    i_cmd      <= cur_item.cmd;
                    i_position <= cur_item.pos;
                    i_value    <= cur_item.val;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                    stim_done  <= 1'b1;
                end
            end
        end
    end

    // Receiver: stall the result channel in short bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idling_on() && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_status, o_data, o_found_index, o_count};
            if (expected_q.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: result with nothing expected: %s %0d %0d %0d %0d",
                             $realtime, "status/data/idx/count",
                             got.status, got.data, got.fidx, got.count);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"%0t: mismatch exp status %0d data %0d idx %0d count %0d,",
                                  " got status %0d data %0d idx %0d count %0d"},
                                 $realtime, want.status, want.data, want.fidx, want.count,
                                 got.status, got.data, got.fidx, got.count);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_table_row fill_row;
        // Empty list: every access fails
        add_row(CMD_READ,       0,    0,    1'b1, ST_RANGE,     0,    NO_INDEX, 0);
        add_row(CMD_FIND,       0,    5,    1'b1, ST_NOT_FOUND, 0,    NO_INDEX, 0);
        add_row(CMD_REMOVE_VAL, 0,    5,    1'b1, ST_NOT_FOUND, 0,    NO_INDEX, 0);
        add_row(CMD_REMOVE_AT,  0,    0,    1'b1, ST_RANGE,     0,    NO_INDEX, 0);
        add_row(CMD_REPLACE,    0,    9,    1'b1, ST_RANGE,     0,    NO_INDEX, 0);
        add_row(CMD_INSERT,     1,    9,    1'b1, ST_RANGE,     0,    NO_INDEX, 0);
        add_row(CMD_INSERT,     -1,   9,    1'b1, ST_RANGE,     0,    NO_INDEX, 0);
        // Build max, min, then prepend zero through a negative position
        add_row(CMD_INSERT,     0,    VMAX, 1'b1, ST_OK,        0,    NO_INDEX, 1);
        add_row(CMD_INSERT,     1,    VMIN, 1'b1, ST_OK,        0,    NO_INDEX, 2);
        add_row(CMD_INSERT,     -2,   0,    1'b1, ST_OK,        0,    NO_INDEX, 3);
        add_row(CMD_READ,       -1,   0,    1'b1, ST_OK,        VMIN, NO_INDEX, 3);
        add_row(CMD_READ,       -3,   0,    1'b1, ST_OK,        0,    NO_INDEX, 3);
        add_row(CMD_READ,       -4,   0,    1'b1, ST_RANGE,     0,    NO_INDEX, 3);
        add_row(CMD_READ,       3,    0,    1'b1, ST_RANGE,     0,    NO_INDEX, 3);
        add_row(CMD_FIND,       0,    VMIN, 1'b1, ST_OK,        0,    2,        3);
        add_row(CMD_REPLACE,    1,    VNEG, 1'b1, ST_OK,        0,    NO_INDEX, 3);
        // Duplicate value: remove by value takes the first match
        add_row(CMD_INSERT,     2,    VNEG, 1'b1, ST_OK,        0,    NO_INDEX, 4);
        add_row(CMD_REMOVE_VAL, 0,    VNEG, 1'b1, ST_OK,        VNEG, 1,        3);
        add_row(CMD_REMOVE_AT,  0,    0,    1'b1, ST_OK,        0,    NO_INDEX, 2);
        add_row(CMD_SPARE_6,    127,  0,    1'b1, ST_OK,        0,    NO_INDEX, 2);
        add_row(CMD_SPARE_7,    -128, VNEG, 1'b1, ST_OK,        0,    NO_INDEX, 2);
        add_row(CMD_INSERT,     127,  0,    1'b1, ST_RANGE,     0,    NO_INDEX, 2);
        add_row(CMD_INSERT,     -128, 0,    1'b1, ST_RANGE,     0,    NO_INDEX, 2);
        add_row(CMD_REMOVE_AT,  2,    0,    1'b1, ST_RANGE,     0,    NO_INDEX, 2);
        // Append random values until the list is full
        fill_row.item     = '0;
        fill_row.item.cmd = CMD_INSERT;
        fill_row.to_end   = 1'b1;
        fill_row.rand_val = 1'b1;
        fill_row.reps     = CAPACITY - 2;
        directed_q.push_back(fill_row);
        // Full list: range check comes before the full check
        add_row(CMD_INSERT,     0,    0,    1'b1, ST_FULL,      0,    NO_INDEX, 64);
        add_row(CMD_INSERT,     64,   0,    1'b1, ST_FULL,      0,    NO_INDEX, 64);
        add_row(CMD_INSERT,     65,   0,    1'b1, ST_RANGE,     0,    NO_INDEX, 64);
        add_row(CMD_INSERT,     -65,  0,    1'b1, ST_RANGE,     0,    NO_INDEX, 64);
        add_row(CMD_READ,       -64,  0,    1'b1, ST_OK,        VNEG, NO_INDEX, 64);
        add_row(CMD_READ,       63,   0,    1'b0);
        add_row(CMD_REMOVE_AT,  -64,  0,    1'b1, ST_OK,        VNEG, NO_INDEX, 63);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(stim_done && expected_q.size() == 0)) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
